// File: sv/assert_macros.svh
// Assertion macros shared by the console writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TCW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("console writer check failed");
`define TCW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("console writer check failed");
`else
`define TCW_ASSERT_IMP(lbl, ante, cons)
`define TCW_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: sv/tcw_pkg.sv
// Types, codes and constants of the text console character writer.
package tcw_pkg;

  localparam int DEF_COLS    = 80;
  localparam int DEF_ROWS    = 25;
  localparam int COORD_W     = 8;
  localparam int CELL_W      = 16;
  localparam int ADDR_W      = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SET_LO = 8'h21;
  localparam logic [7:0] CH_SET_HI = 8'h7f;

  typedef enum logic [2:0] {
    OP_PUT        = 3'd0,
    OP_SET_CHAR   = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_SET_CURSOR = 3'd3,
    OP_READ       = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_READ,
    CMD_SCROLL,
    CMD_CLEAR
  } cmd_kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_SCROLL,
    B_FILL,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         char_code;
    logic [3:0]         fore_colour;
    logic [3:0]         back_colour;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } in_t;

  typedef struct packed {
    logic [6:0]        cursor_col;
    logic [4:0]        cursor_row;
    logic [CELL_W-1:0] cell_value;
    logic              ignored;
  } out_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
    logic              last;
    out_t              res;
  } cmd_t;

endpackage

// File: sv/tcw_ram.sv
// Generic simple dual-port RAM with registered read.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/tcw_queue.sv
// Short command queue between the front and back of the console writer.
module tcw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output tcw_pkg::cmd_t q_cmd
);
  import tcw_pkg::*;

  localparam int QA = $clog2(QUEUE_DEPTH);
  localparam logic [QA-1:0] LAST_PTR = QA'(QUEUE_DEPTH - 1);
  localparam logic [QA:0]   FULL_CNT = (QA+1)'(QUEUE_DEPTH);

  cmd_t          entry_r [QUEUE_DEPTH];
  logic [QA-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QA-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QA:0]   count_r, count_nxt;

  assign full    = (count_r == FULL_CNT);
  assign q_valid = (count_r != '0);
  assign q_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: sv/tcw_front.sv
// Front end: accepts words, tracks the cursor and issues screen commands.
module tcw_front #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tcw_pkg::in_t  in_data,
  input  logic          init_busy,
  input  logic          q_full,
  output logic          push,
  output tcw_pkg::cmd_t push_cmd
);
  import tcw_pkg::*;

  localparam logic [COORD_W-1:0] COLS_C  = COORD_W'(COLS);
  localparam logic [COORD_W-1:0] COLS_M1 = COORD_W'(COLS - 1);
  localparam logic [COORD_W-1:0] ROWS_C  = COORD_W'(ROWS);
  localparam logic [COORD_W-1:0] ROWS_M1 = COORD_W'(ROWS - 1);

  logic [COORD_W-1:0] cc_r, cc_nxt;
  logic [COORD_W-1:0] cl_r, cl_nxt;
  logic               pre_r, pre_nxt;
  logic               main_r, main_nxt;
  logic               post_r, post_nxt;
  cmd_t               cmd_r;

  logic               accept;
  logic               busy;
  logic               in_range;
  logic [7:0]         attr;
  logic [COORD_W-1:0] nc, nl, c1, l1, c2, sel_col, sel_row;
  logic               pre, post, ign;
  cmd_kind_t          kind;
  logic [CELL_W-1:0]  data;
  logic [ADDR_W-1:0]  addr;
  out_t               res;

  // Classify the incoming word and plan its commands
  always_comb begin
    attr     = {in_data.back_colour, in_data.fore_colour};
    in_range = (in_data.col < COLS_C) && (in_data.row < ROWS_C);
    nc       = cc_r;
    nl       = cl_r;
    c1       = cc_r;
    l1       = cl_r;
    c2       = cc_r;
    sel_col  = cc_r;
    sel_row  = cl_r;
    pre      = 1'b0;
    post     = 1'b0;
    ign      = 1'b0;
    kind     = CMD_NONE;
    data     = '0;
    case (in_data.opcode)
      OP_PUT: begin
        if (in_data.char_code == CH_BS) begin
          c1      = (cc_r != '0) ? cc_r - 1'b1 : cc_r;
          nc      = c1;
          sel_col = c1;
          kind    = CMD_WRITE;
          data    = {attr, CH_SPACE};
        end else if (in_data.char_code == CH_CR) begin
          nc = '0;
        end else if (in_data.char_code == CH_LF) begin
          nc = '0;
          if (cl_r >= ROWS_M1) begin
            kind = CMD_SCROLL;
          end else begin
            nl = cl_r + 1'b1;
          end
        end else begin
          // wrap before the write when parked on the last column
          if (cc_r >= COLS_M1) begin
            c1 = '0;
            if (cl_r >= ROWS_M1) begin
              pre = 1'b1;
            end else begin
              l1 = cl_r + 1'b1;
            end
          end
          sel_col = c1;
          sel_row = l1;
          kind    = CMD_WRITE;
          data    = {attr, in_data.char_code};
          c2      = c1 + 1'b1;
          if (c2 >= COLS_M1) begin
            nc = '0;
            if (l1 >= ROWS_M1) begin
              post = 1'b1;
              nl   = l1;
            end else begin
              nl = l1 + 1'b1;
            end
          end else begin
            nc = c2;
            nl = l1;
          end
        end
      end
      OP_SET_CHAR: begin
        if (in_range && in_data.char_code >= CH_SET_LO && in_data.char_code <= CH_SET_HI) begin
          kind    = CMD_WRITE;
          data    = {attr, in_data.char_code};
          sel_col = in_data.col;
          sel_row = in_data.row;
        end else begin
          ign = 1'b1;
        end
      end
      OP_CLEAR: begin
        kind = CMD_CLEAR;
        data = {attr, CH_SPACE};
        nc   = '0;
        nl   = '0;
      end
      OP_SET_CURSOR: begin
        if (in_range) begin
          nc = in_data.col;
          nl = in_data.row;
        end else begin
          ign = 1'b1;
        end
      end
      OP_READ: begin
        if (in_range) begin
          kind    = CMD_READ;
          sel_col = in_data.col;
          sel_row = in_data.row;
        end else begin
          ign = 1'b1;
        end
      end
      default: begin
      end
    endcase
    addr = ADDR_W'(sel_row) * ADDR_W'(COLS) + ADDR_W'(sel_col);
    res.cursor_col = nc[6:0];
    res.cursor_row = nl[4:0];
    res.cell_value = '0;
    res.ignored    = ign;
  end

  // Issue the planned commands in order: wrap scroll, main, trailing scroll
  always_comb begin
    busy          = pre_r || main_r || post_r;
    push          = busy && !q_full;
    pre_nxt       = pre_r;
    main_nxt      = main_r;
    post_nxt      = post_r;
    push_cmd.kind = CMD_SCROLL;
    push_cmd.addr = '0;
    push_cmd.data = '0;
    push_cmd.last = 1'b1;
    push_cmd.res  = cmd_r.res;
    if (pre_r) begin
      push_cmd.last = !main_r && !post_r;
      if (push) begin
        pre_nxt = 1'b0;
      end
    end else if (main_r) begin
      push_cmd      = cmd_r;
      push_cmd.last = !post_r;
      if (push) begin
        main_nxt = 1'b0;
      end
    end else if (push) begin
      post_nxt = 1'b0;
    end
    in_stall = init_busy || (busy && !(push && push_cmd.last));
    accept   = in_valid && !in_stall;
    cc_nxt   = cc_r;
    cl_nxt   = cl_r;
    if (accept) begin
      pre_nxt  = pre;
      main_nxt = 1'b1;
      post_nxt = post;
      cc_nxt   = nc;
      cl_nxt   = nl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r   <= '0;
      cl_r   <= '0;
      pre_r  <= 1'b0;
      main_r <= 1'b0;
      post_r <= 1'b0;
    end else begin
      cc_r   <= cc_nxt;
      cl_r   <= cl_nxt;
      pre_r  <= pre_nxt;
      main_r <= main_nxt;
      post_r <= post_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.kind <= kind;
      cmd_r.addr <= addr;
      cmd_r.data <= data;
      cmd_r.last <= 1'b1;
      cmd_r.res  <= res;
    end
  end

endmodule

// File: sv/tcw_back.sv
// Back end: carries out screen commands on the cell memory and returns results.
module tcw_back #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  tcw_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          init_busy,
  output logic          out_valid,
  input  logic          out_stall,
  output tcw_pkg::out_t out_data
);
  import tcw_pkg::*;

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0] LAST_A = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_N = AW'(COLS * (ROWS - 1));
  localparam logic [AW-1:0] COLS_A = AW'(COLS);

  back_state_t       state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  out_t              res_r, res_nxt;
  logic              last_r, last_nxt;
  logic [CELL_W-1:0] fill_r, fill_nxt;
  logic              init_r, init_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic              out_free;
  logic              emit;
  out_t              emit_data;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign init_busy = init_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    last_nxt  = last_r;
    fill_nxt  = fill_r;
    init_nxt  = init_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    waddr     = cnt_r;
    wdata     = fill_r;
    re        = 1'b0;
    raddr     = q_cmd.addr[AW-1:0];
    emit      = 1'b0;
    emit_data = res_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            CMD_WRITE, CMD_NONE: begin
              // hold a final command until the output register can take it
              if (!q_cmd.last || out_free) begin
                q_pop     = 1'b1;
                we        = (q_cmd.kind == CMD_WRITE);
                waddr     = q_cmd.addr[AW-1:0];
                wdata     = q_cmd.data;
                emit      = q_cmd.last;
                emit_data = q_cmd.res;
              end
            end
            CMD_READ: begin
              q_pop     = 1'b1;
              re        = 1'b1;
              res_nxt   = q_cmd.res;
              state_nxt = B_READ;
            end
            CMD_SCROLL: begin
              q_pop     = 1'b1;
              cnt_nxt   = '0;
              res_nxt   = q_cmd.res;
              last_nxt  = q_cmd.last;
              fill_nxt  = BLANK_CELL;
              state_nxt = B_SCROLL;
            end
            CMD_CLEAR: begin
              q_pop     = 1'b1;
              cnt_nxt   = '0;
              res_nxt   = q_cmd.res;
              last_nxt  = q_cmd.last;
              fill_nxt  = q_cmd.data;
              state_nxt = B_FILL;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      B_READ: begin
        if (out_free) begin
          emit                 = 1'b1;
          emit_data.cell_value = rdata;
          state_nxt            = B_IDLE;
        end
      end
      B_SCROLL: begin
        // read one row ahead, write the cell fetched last cycle one row up
        if (cnt_r != COPY_N) begin
          re    = 1'b1;
          raddr = cnt_r + COLS_A;
        end
        if (cnt_r != '0) begin
          we    = 1'b1;
          waddr = cnt_r - 1'b1;
          wdata = rdata;
        end
        if (cnt_r == COPY_N) begin
          state_nxt = B_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      B_FILL: begin
        we = 1'b1;
        if (cnt_r == LAST_A) begin
          state_nxt = B_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      B_DONE: begin
        init_nxt = 1'b0;
        if (!last_r) begin
          state_nxt = B_IDLE;
        end else if (out_free) begin
          emit      = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
    out_data_nxt  = emit ? emit_data : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_FILL;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      fill_r      <= BLANK_CELL;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      fill_r      <= fill_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: sv/text_console_char_writer_unit.sv
// Text console character writer: top level with front, queue and back.
// Input words (in_valid/in_stall/in_data) carry one console operation each;
// every accepted word returns exactly one result word on out_valid/out_stall/
// out_data with the cursor after the operation, the cell read and a flag for
// rejected coordinates or codes.
// The front tracks the cursor and accepts one word per cycle unless in_stall
// is high; it turns each word into one to three commands for the back
// through a four-entry queue. The back owns the single-write, single-read
// cell memory and carries out one command at a time: a cell write, cursor
// move or rejected word, a cell read, a clear that walks the whole memory, or
// a scroll (line feed or wrap on the bottom row) that walks it too.
// After reset the back fills every cell with a blank; in_stall stays high
// until it is done.
// A stalled result word holds in the output register while the back goes on
// with queued commands; it stops only when a second result is ready.
`include "assert_macros.svh"
module text_console_char_writer_unit #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tcw_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tcw_pkg::out_t out_data
);
  import tcw_pkg::*;

  logic init_busy;
  logic q_full;
  logic q_push;
  cmd_t push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;

  tcw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .init_busy (init_busy),
    .q_full    (q_full),
    .push      (q_push),
    .push_cmd  (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  tcw_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `TCW_ASSERT_IMP(a_init_blocks_input, init_busy, in_stall)
  `TCW_ASSERT_IMP(a_no_push_when_full, q_push, !q_full)
  `TCW_ASSERT_IMP(a_pop_only_valid, q_pop, q_valid)
  `TCW_ASSERT_IMP(a_ignored_has_no_cell, out_valid && out_data.ignored, out_data.cell_value == '0)

endmodule

// File: dv/console_screen_checker.sv
// Console writer checker: predicts every result word and compares it with the block's output.
module console_screen_checker #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  tcw_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  tcw_pkg::out_t out_data,
  output int            mismatch_count,
  output int            results_pending,
  output int            results_checked,
  output int            scroll_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  logic [CELL_W-1:0] screen_image [COLS*ROWS];
  int                cur_col;
  int                cur_row;
  out_t              expected_results [$];

  function void reset_console();
    foreach (screen_image[i]) screen_image[i] = BLANK_CELL;
    cur_col = 0;
    cur_row = 0;
  endfunction

  function void scroll_screen();
    for (int i = 0; i < COLS * (ROWS - 1); i++) screen_image[i] = screen_image[i + COLS];
    for (int i = COLS * (ROWS - 1); i < COLS * ROWS; i++) screen_image[i] = BLANK_CELL;
    scroll_count++;
  endfunction

  // Go to column 0 of the next line, scrolling when already on the bottom line.
  function void advance_line();
    if (cur_row >= ROWS - 1) begin
      scroll_screen();
    end else begin
      cur_row++;
    end
    cur_col = 0;
  endfunction

  function void put_char(logic [7:0] ch, logic [7:0] attr);
    if (ch == CH_BS) begin
      if (cur_col > 0) cur_col--;
      screen_image[cur_row * COLS + cur_col] = {attr, CH_SPACE};
    end else if (ch == CH_CR) begin
      cur_col = 0;
    end else if (ch == CH_LF) begin
      advance_line();
    end else begin
      // never write the last column: wrap before and after the write
      if (cur_col >= COLS - 1) advance_line();
      screen_image[cur_row * COLS + cur_col] = {attr, ch};
      cur_col++;
      if (cur_col >= COLS - 1) advance_line();
    end
  endfunction

  function out_t predict_word(in_t w);
    out_t       res;
    logic [7:0] attr;
    logic       on_screen;
    attr      = {w.back_colour, w.fore_colour};
    on_screen = (int'(w.col) < COLS) && (int'(w.row) < ROWS);
    res.cell_value = '0;
    res.ignored    = 1'b0;
    case (w.opcode)
      OP_PUT: begin
        put_char(w.char_code, attr);
      end
      OP_SET_CHAR: begin
        if (on_screen && w.char_code >= CH_SET_LO && w.char_code <= CH_SET_HI) begin
          screen_image[int'(w.row) * COLS + int'(w.col)] = {attr, w.char_code};
        end else begin
          res.ignored = 1'b1;
        end
      end
      OP_CLEAR: begin
        foreach (screen_image[i]) screen_image[i] = {attr, CH_SPACE};
        cur_col = 0;
        cur_row = 0;
      end
      OP_SET_CURSOR: begin
        if (on_screen) begin
          cur_col = int'(w.col);
          cur_row = int'(w.row);
        end else begin
          res.ignored = 1'b1;
        end
      end
      OP_READ: begin
        if (on_screen) begin
          res.cell_value = screen_image[int'(w.row) * COLS + int'(w.col)];
        end else begin
          res.ignored = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.cursor_col = 7'(cur_col);
    res.cursor_row = 5'(cur_row);
    return res;
  endfunction

  function void check_field(string name, logic [CELL_W-1:0] want, logic [CELL_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      reset_console();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with no operation outstanding: %p", out_data);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("cursor_col", CELL_W'(want.cursor_col), CELL_W'(out_data.cursor_col));
          check_field("cursor_row", CELL_W'(want.cursor_row), CELL_W'(out_data.cursor_row));
          check_field("cell_value", want.cell_value, out_data.cell_value);
          check_field("ignored", CELL_W'(want.ignored), CELL_W'(out_data.ignored));
          results_checked++;
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(predict_word(in_data));
    end
    results_pending = expected_results.size();
  end

endmodule

// File: dv/text_console_char_writer_unit_test.sv
// Testbench top for the console writer: clock, reset, stimulus, result stalls and verdict.
module text_console_char_writer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLS        = DEF_COLS;
  localparam int ROWS        = DEF_ROWS;
  localparam int ITEM_TARGET = 1500;
  localparam int MAX_GAP     = 13;
  // every word a full-screen walk with both sides at their longest gap, three times over
  localparam int CYCLE_LIMIT = 3 * (2 * ITEM_TARGET + 50) * (2 * MAX_GAP + COLS * ROWS + 12)
                               + COLS * ROWS + 100;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  in_t   in_data;
  logic  out_valid;
  logic  out_stall;
  out_t  out_data;

  int    mismatch_count;
  int    results_pending;
  int    results_checked;
  int    scroll_count;
  int    words_sent;
  int    noise_words;
  int    clears_sent;
  int    cycle_total;
  bit    in_steady;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  text_console_char_writer_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  console_screen_checker #(.COLS(COLS), .ROWS(ROWS)) screen_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending),
    .results_checked(results_checked),
    .scroll_count   (scroll_count)
  );

  // Present one operation word after a random gap and hold it until accepted.
  task automatic send(input logic [2:0] op, input logic [7:0] ch, input logic [3:0] fore,
                      input logic [3:0] back, input logic [7:0] c, input logic [7:0] r);
    int gap;
    if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{opcode: op, char_code: ch, fore_colour: fore, back_colour: back,
                 col: c, row: r};
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (op == OP_CLEAR) clears_sent++;
  endtask

  // Drop valid and hold off until every outstanding result has been returned.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] noise_coord(int span);
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'($urandom_range(span - 1, span));
      default: return 8'($urandom_range(0, span - 1));
    endcase
  endfunction

  function automatic logic [7:0] text_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 8'($urandom_range(CH_SPACE, 8'h7e));
    if (pick < 78) return CH_BS;
    if (pick < 84) return CH_CR;
    if (pick < 90) return CH_LF;
    return 8'($urandom_range(0, 255));
  endfunction

  // result side: stall for a random number of cycles per word, with quiet stretches
  initial begin
    int  hold;
    bit  out_steady;
    out_stall  = 1'b0;
    out_steady = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
      hold = out_steady ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      out_stall = (hold != 0);
      repeat (hold) @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    cycle_total = 0;
    forever begin
      @(posedge clk);
      cycle_total++;
      if (cycle_total > CYCLE_LIMIT) begin
        $display("text_console_char_writer_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    int         pick;
    int         burst;
    int         paint_col [6];
    int         paint_row [6];
    int         fails;
    logic [7:0] start_row;
    logic [7:0] start_col;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    in_steady = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // corners and out-of-range reads on the fresh screen
    send(OP_READ, 8'h00, 4'h0, 4'h0, 8'd0, 8'd0);
    send(OP_READ, 8'h00, 4'h0, 4'h0, 8'(COLS - 1), 8'(ROWS - 1));
    send(OP_READ, 8'h00, 4'h0, 4'h0, 8'(COLS), 8'd0);
    send(OP_READ, 8'h00, 4'h0, 4'h0, 8'd0, 8'hff);
    // advance into the last usable column on the bottom line: wraps and scrolls
    send(OP_SET_CURSOR, 8'h00, 4'h0, 4'h0, 8'(COLS - 2), 8'(ROWS - 1));
    send(OP_PUT, 8'h41, 4'hf, 4'h0, 8'd0, 8'd0);
    // cursor parked on the last column wraps before writing
    send(OP_SET_CURSOR, 8'h00, 4'h0, 4'h0, 8'(COLS - 1), 8'd0);
    send(OP_PUT, 8'h42, 4'h0, 4'hf, 8'd0, 8'd0);
    // backspace mid-line, then at column 0
    send(OP_PUT, CH_BS, 4'h5, 4'ha, 8'd0, 8'd0);
    send(OP_PUT, CH_BS, 4'ha, 4'h5, 8'd0, 8'd0);
    send(OP_PUT, 8'hff, 4'hf, 4'hf, 8'd0, 8'd0);
    send(OP_PUT, CH_CR, 4'h0, 4'h0, 8'd0, 8'd0);
    // line feed on the bottom line scrolls
    send(OP_SET_CURSOR, 8'h00, 4'h0, 4'h0, 8'd5, 8'(ROWS - 1));
    send(OP_PUT, CH_LF, 4'h0, 4'h0, 8'd0, 8'd0);
    // set char: both ends of the accepted codes, then each kind of rejection
    send(OP_SET_CHAR, CH_SET_LO, 4'hf, 4'h0, 8'(COLS - 1), 8'(ROWS - 1));
    send(OP_SET_CHAR, CH_SET_HI, 4'h0, 4'hf, 8'd0, 8'd0);
    send(OP_SET_CHAR, CH_SPACE, 4'h3, 4'h3, 8'd1, 8'd1);
    send(OP_SET_CHAR, CH_SET_HI + 8'd1, 4'h3, 4'h3, 8'd1, 8'd1);
    send(OP_SET_CHAR, 8'h50, 4'h3, 4'h3, 8'(COLS), 8'd1);
    send(OP_SET_CHAR, 8'h50, 4'h3, 4'h3, 8'd1, 8'(ROWS));
    send(OP_SET_CURSOR, 8'h00, 4'h0, 4'h0, 8'hff, 8'hff);
    send(OP_READ, 8'h00, 4'h0, 4'h0, 8'(COLS - 1), 8'(ROWS - 1));
    send(OP_READ, 8'h00, 4'h0, 4'h0, 8'd0, 8'd0);
    // spare opcodes change nothing
    for (int k = int'(OP_READ) + 1; k < 8; k++) send(3'(k), 8'hff, 4'hf, 4'hf, 8'hff, 8'hff);
    send(OP_CLEAR, 8'h00, 4'hf, 4'hf, 8'd0, 8'd0);
    send(OP_READ, 8'h00, 4'h0, 4'h0, 8'd40, 8'd12);
    drain();

    while (words_sent - noise_words < ITEM_TARGET) begin
      if ($urandom_range(0, 49) == 0) drain();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // malformed traffic: any opcode, coordinates around and past the edges
        burst = $urandom_range(1, 3);
        repeat (burst) begin
          send(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
               4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
               noise_coord(COLS), noise_coord(ROWS));
          noise_words++;
        end
      end else if (pick < 17) begin
        send(OP_CLEAR, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
             4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (pick < 55) begin
        // a line of text from a fresh cursor position; mostly away from the bottom
        start_row = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(ROWS - 3, ROWS - 1))
                                                : 8'($urandom_range(0, ROWS - 4));
        start_col = $urandom_range(0, 1) ? 8'($urandom_range(0, COLS - 1))
                                         : 8'($urandom_range(COLS - 6, COLS - 1));
        send(OP_SET_CURSOR, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
             4'($urandom_range(0, 15)), start_col, start_row);
        burst = $urandom_range(3, 12);
        repeat (burst) begin
          send(OP_PUT, text_byte(), 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        send(OP_READ, 8'h00, 4'h0, 4'h0, 8'($urandom_range(0, COLS - 1)), start_row);
      end else if (pick < 80) begin
        // paint cells at coordinates, then read them back
        burst = $urandom_range(2, 6);
        for (int k = 0; k < burst; k++) begin
          paint_col[k] = $urandom_range(0, COLS - 1);
          paint_row[k] = $urandom_range(0, ROWS - 1);
          send(OP_SET_CHAR, 8'($urandom_range(CH_SET_LO, CH_SET_HI)),
               4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
               8'(paint_col[k]), 8'(paint_row[k]));
        end
        for (int k = 0; k < burst; k++) begin
          send(OP_READ, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
               4'($urandom_range(0, 15)), 8'(paint_col[k]), 8'(paint_row[k]));
        end
      end else if (pick < 92) begin
        burst = $urandom_range(2, 6);
        repeat (burst) begin
          send(OP_READ, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
               4'($urandom_range(0, 15)), 8'($urandom_range(0, COLS - 1)),
               8'($urandom_range(0, ROWS - 1)));
        end
      end else begin
        send(OP_SET_CURSOR, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
             4'($urandom_range(0, 15)), 8'($urandom_range(0, COLS - 1)),
             8'($urandom_range(0, ROWS - 1)));
        send(OP_READ, 8'h00, 4'h0, 4'h0, 8'($urandom_range(0, COLS - 1)),
             8'($urandom_range(0, ROWS - 1)));
      end
    end

    drain();
    repeat (20) @(negedge clk);
    fails = mismatch_count + results_pending;
    if (results_pending != 0) $error("%0d result words never returned", results_pending);

    $display("Run covered %0d operation words (%0d malformed or off-screen), %0d results compared.",
             words_sent, noise_words, results_checked);
    $display("Screen traffic included %0d scrolls and %0d clears.", scroll_count, clears_sent);
    if (fails == 0) begin
      $display("text_console_char_writer_unit verification clean");
    end else begin
      $display("text_console_char_writer_unit verification failed");
    end
    $finish;
  end

endmodule
